// ===== hw/rtl/sm3_pkg.sv =====
// SM3 hash engine: shared constants, types and bit functions.
// No dependencies; compiled first.
package sm3_pkg;

  localparam int QUEUE_DEPTH = 16;

  localparam logic [31:0] TJ_LOW   = 32'h79cc4519;
  localparam logic [31:0] TJ_HIGH  = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_START = 6'd56;
  localparam logic [5:0]  LAST_POS  = 6'd63;

  localparam logic [31:0] IV [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  // One message word on its way to the compression side.
  typedef struct packed {
    logic [31:0] word;
    logic        final_word;
  } word_ent_t;

  // Queue status seen by the producer and the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // Round constant rotated by j mod 32.
  function automatic logic [31:0] tj_rot(input logic [5:0] j);
    return rotl((j[5:4] == 2'd0) ? TJ_LOW : TJ_HIGH, j[4:0]);
  endfunction

endpackage

// ===== hw/rtl/sm3_stream_if.sv =====
// SM3 hash engine: valid/ready channel interfaces for bytes in and digest out.
// No dependencies.
interface sm3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hw/rtl/sm3_hash_engine_core.sv =====
// SM3 hash engine top: front end, word queue, compression core.
// Bytes are taken one per cycle while the queue has room, outside padding;
// each 64-byte block costs 16 queue reads, 64 rounds and one feed-forward step.
// Closing a message adds up to 72 padding bytes, then 8 digest items.
// Reset (synchronous, rst_n low) reloads the initial value and empties the queue.
module sm3_hash_engine_core #(
  parameter int FIFO_DEPTH = sm3_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  sm3_in_if.sink     in_chan,
  sm3_out_if.source  out_chan
);
  import sm3_pkg::*;

  word_ent_t push_ent, pop_ent;
  q_stat_t   q_stat;
  logic      push, pop;

  // Front end: byte intake, length count, padding, word packing.
  sm3_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_stat   (q_stat),
    .push     (push),
    .push_ent (push_ent)
  );

  // Queue decouples intake from compression.
  sm3_word_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .pop_ent  (pop_ent),
    .q_stat   (q_stat)
  );

  // Back end: expansion, rounds, feed-forward, digest output.
  sm3_compress u_compress (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_ent  (pop_ent),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // The front never takes an item when the queue cannot hold a word.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !q_stat.full)
    else $error("input ready with full queue");

  // Last digest word always carries index 7.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.last_word |-> out_chan.word_index == 3'd7)
    else $error("last word flag on wrong index");

  // After the final digest word leaves, output goes quiet.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ready && out_chan.last_word |=> !out_chan.valid)
    else $error("digest output continued past last word");

endmodule

// ===== hw/rtl/sm3_front.sv =====
// SM3 front end: accepts bytes, counts length, inserts padding, packs words.
// Depends on sm3_pkg and sm3_stream_if.
module sm3_front (
  input  logic               clk,
  input  logic               rst_n,
  sm3_in_if.sink             in_chan,
  input  sm3_pkg::q_stat_t   q_stat,
  output logic               push,
  output sm3_pkg::word_ent_t push_ent
);
  import sm3_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_PAD  = 2'b10
  } front_state_t;

  front_state_t state_r, state_nxt;
  logic [5:0]   fill_r;
  logic [63:0]  msg_bytes_r;
  logic [63:0]  len_sh_r;
  logic [23:0]  word_r;
  logic         first_r, len_ph_r;

  logic       acc, emit_v, emit_last, len_byte;
  logic [7:0] emit_b;

  assign in_chan.ready = (state_r == F_IDLE) && !q_stat.full;
  assign acc = in_chan.valid && in_chan.ready;
  assign len_byte = !first_r && (len_ph_r || fill_r == LEN_START);

  always_comb begin
    emit_v    = 1'b0;
    emit_b    = in_chan.data_byte;
    emit_last = 1'b0;
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        emit_v = acc && in_chan.byte_present;
        if (acc && in_chan.end_of_message) state_nxt = F_PAD;
      end
      F_PAD: begin
        emit_v = !q_stat.full;
        if (first_r) emit_b = PAD_BYTE;
        else if (len_byte) emit_b = len_sh_r[63:56];
        else emit_b = 8'h00;
        emit_last = len_byte && fill_r == LAST_POS;
        if (emit_v && emit_last) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign push = emit_v && (fill_r[1:0] == 2'd3);
  assign push_ent = '{word: {word_r, emit_b}, final_word: emit_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      fill_r      <= '0;
      msg_bytes_r <= '0;
      first_r     <= 1'b0;
      len_ph_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_v) begin
        fill_r <= fill_r + 6'd1;
        word_r <= {word_r[15:0], emit_b};
      end
      if (state_r == F_IDLE && acc) begin
        if (in_chan.end_of_message) begin
          // capture bit length including this item's byte, then restart count
          len_sh_r    <= (msg_bytes_r + {63'd0, in_chan.byte_present}) << 3;
          msg_bytes_r <= '0;
          first_r     <= 1'b1;
          len_ph_r    <= 1'b0;
        end else if (in_chan.byte_present) begin
          msg_bytes_r <= msg_bytes_r + 64'd1;
        end
      end
      if (state_r == F_PAD && emit_v) begin
        first_r <= 1'b0;
        if (len_byte) begin
          len_ph_r <= !emit_last;
          len_sh_r <= len_sh_r << 8;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/sm3_word_fifo.sv =====
// SM3 word queue between the front end and the compression core.
// Depends on sm3_pkg.
module sm3_word_fifo #(
  parameter int DEPTH = sm3_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sm3_pkg::word_ent_t push_ent,
  input  logic               pop,
  output sm3_pkg::word_ent_t pop_ent,
  output sm3_pkg::q_stat_t   q_stat
);
  import sm3_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  word_ent_t       mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign pop_ent = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (do_pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end
endmodule

// ===== hw/rtl/sm3_compress.sv =====
// SM3 compression core: loads 16 words, expands on the fly, one round per cycle.
// Depends on sm3_pkg and sm3_stream_if.
module sm3_compress (
  input  logic               clk,
  input  logic               rst_n,
  input  sm3_pkg::q_stat_t   q_stat,
  input  sm3_pkg::word_ent_t pop_ent,
  output logic               pop,
  sm3_out_if.source          out_chan
);
  import sm3_pkg::*;

  typedef enum logic [3:0] {
    B_LOAD  = 4'b0001,
    B_ROUND = 4'b0010,
    B_XOR   = 4'b0100,
    B_EMIT  = 4'b1000
  } back_state_t;

  back_state_t  state_r;
  logic [31:0]  w_r  [16];
  logic [31:0]  r_r  [8];
  logic [31:0]  cv_r [8];
  logic [5:0]   rnd_r;
  logic [2:0]   oidx_r;
  logic         final_r;

  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;

  assign pop = (state_r == B_LOAD) && !q_stat.empty;

  always_comb begin
    a12 = rotl(r_r[0], 5'd12);
    ss1 = rotl(a12 + r_r[4] + tj_rot(rnd_r), 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd_r[5:4] == 2'd0) begin
      ff = r_r[0] ^ r_r[1] ^ r_r[2];
      gg = r_r[4] ^ r_r[5] ^ r_r[6];
    end else begin
      ff = (r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]);
      gg = (r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]);
    end
    tt1   = ff + r_r[3] + ss2 + (w_r[0] ^ w_r[4]);
    tt2   = gg + r_r[7] + ss1 + w_r[0];
    w_new = perm1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15)) ^ rotl(w_r[3], 5'd7) ^ w_r[10];
  end

  assign out_chan.valid       = (state_r == B_EMIT);
  assign out_chan.digest_word = cv_r[oidx_r];
  assign out_chan.word_index  = oidx_r;
  assign out_chan.last_word   = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_LOAD;
      rnd_r   <= '0;
      oidx_r  <= '0;
      final_r <= 1'b0;
      for (int i = 0; i < 8; i++) cv_r[i] <= IV[i];
    end else begin
      case (state_r)
        B_LOAD: begin
          if (pop) begin
            for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
            w_r[15] <= pop_ent.word;
            rnd_r   <= rnd_r + 6'd1;
            if (rnd_r[3:0] == 4'd15) begin
              final_r <= pop_ent.final_word;
              for (int i = 0; i < 8; i++) r_r[i] <= cv_r[i];
              rnd_r   <= '0;
              state_r <= B_ROUND;
            end
          end
        end
        B_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
          w_r[15] <= w_new;
          r_r[0] <= tt1;
          r_r[1] <= r_r[0];
          r_r[2] <= rotl(r_r[1], 5'd9);
          r_r[3] <= r_r[2];
          r_r[4] <= perm0(tt2);
          r_r[5] <= r_r[4];
          r_r[6] <= rotl(r_r[5], 5'd19);
          r_r[7] <= r_r[6];
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= B_XOR;
        end
        B_XOR: begin
          for (int i = 0; i < 8; i++) cv_r[i] <= cv_r[i] ^ r_r[i];
          oidx_r  <= '0;
          state_r <= final_r ? B_EMIT : B_LOAD;
        end
        B_EMIT: begin
          if (out_chan.ready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              // reload initial value for the next message
              for (int i = 0; i < 8; i++) cv_r[i] <= IV[i];
              state_r <= B_LOAD;
            end
          end
        end
        default: state_r <= B_LOAD;
      endcase
    end
  end
endmodule

// ===== test/sm3_hash_engine_core_test.sv =====
// Self-checking bench for the SM3 hash engine: drives byte items, predicts the digest.
// Depends on sm3_pkg and the channel interfaces in hw/rtl.
module sm3_hash_engine_core_test;
  import sm3_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  logic clk;
  logic rst_n;
  sm3_in_if  in_chan();
  sm3_out_if out_chan();

  sm3_hash_engine_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  // Predictor state: a private copy of the hash state.
  logic [31:0] chain_val [8];
  logic [7:0]  blk_buf [64];
  int          blk_fill;
  logic [63:0] msg_len;

  byte_item_t   pending_bytes [$];
  digest_item_t digest_queue [$];
  int  mismatch_count = 0;
  bit  quiet_tail = 0;
  bit  hold_send = 0;
  int  send_gap = 0;
  int  recv_gap = 0;

  function automatic logic [31:0] rot32(logic [31:0] x, int n);
    n = n % 32;
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function automatic logic [31:0] p0_mix(logic [31:0] x);
    return x ^ rot32(x, 9) ^ rot32(x, 17);
  endfunction

  function automatic logic [31:0] p1_mix(logic [31:0] x);
    return x ^ rot32(x, 15) ^ rot32(x, 23);
  endfunction

  // Run the compression function over blk_buf into chain_val.
  task automatic compress_block();
    logic [31:0] w [68];
    logic [31:0] wx [64];
    logic [31:0] r [8];
    logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (int i = 16; i < 68; i++)
      w[i] = p1_mix(w[i-16] ^ w[i-9] ^ rot32(w[i-3], 15)) ^ rot32(w[i-13], 7) ^ w[i-6];
    for (int i = 0; i < 64; i++) wx[i] = w[i] ^ w[i+4];
    for (int i = 0; i < 8; i++) r[i] = chain_val[i];
    for (int i = 0; i < 64; i++) begin
      tj  = (i < 16) ? 32'h79cc4519 : 32'h7a879d8a;
      a12 = rot32(r[0], 12);
      ss1 = rot32(a12 + r[4] + rot32(tj, i), 7);
      ss2 = ss1 ^ a12;
      if (i < 16) begin
        ff = r[0] ^ r[1] ^ r[2];
        gg = r[4] ^ r[5] ^ r[6];
      end else begin
        ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        gg = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      tt1 = ff + r[3] + ss2 + wx[i];
      tt2 = gg + r[7] + ss1 + w[i];
      r[3] = r[2];
      r[2] = rot32(r[1], 9);
      r[1] = r[0];
      r[0] = tt1;
      r[7] = r[6];
      r[6] = rot32(r[5], 19);
      r[5] = r[4];
      r[4] = p0_mix(tt2);
    end
    for (int i = 0; i < 8; i++) chain_val[i] ^= r[i];
  endtask

  task automatic reload_hash();
    for (int i = 0; i < 8; i++) chain_val[i] = IV[i];
    blk_fill = 0;
    msg_len  = '0;
  endtask

  // Absorb one accepted item; on end of message, pad and queue the digest.
  task automatic absorb_item(byte_item_t it);
    logic [63:0] bits;
    if (it.byte_present) begin
      blk_buf[blk_fill] = it.data_byte;
      blk_fill++;
      msg_len++;
      if (blk_fill == 64) begin
        compress_block();
        blk_fill = 0;
      end
    end
    if (!it.end_of_message) return;
    blk_buf[blk_fill] = PAD_BYTE;
    blk_fill++;
    if (blk_fill > 56) begin
      while (blk_fill < 64) begin
        blk_buf[blk_fill] = 8'h00;
        blk_fill++;
      end
      compress_block();
      blk_fill = 0;
    end
    while (blk_fill < 56) begin
      blk_buf[blk_fill] = 8'h00;
      blk_fill++;
    end
    bits = msg_len << 3;
    for (int k = 0; k < 8; k++) blk_buf[56+k] = bits[63-8*k -: 8];
    compress_block();
    for (int k = 0; k < 8; k++)
      digest_queue.push_back('{chain_val[k], 3'(k), k == 7});
    reload_hash();
  endtask

  function automatic byte_item_t mk(logic [7:0] b, logic p, logic e);
    return '{b, p, e};
  endfunction

  // Queue a message of n random bytes; the end may ride on the last byte or stand alone.
  task automatic queue_message(int n, bit end_with_byte);
    for (int i = 0; i < n; i++)
      pending_bytes.push_back(mk(8'($urandom_range(0, 255)), 1'b1,
                                 end_with_byte && (i == n - 1)));
    if (!end_with_byte || n == 0)
      pending_bytes.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
  endtask

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Driver: present the head of pending_bytes, hold it until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        absorb_item(pending_bytes.pop_front());
      end
      if (in_chan.valid && !(in_chan.ready)) begin
        // hold the current item
      end else if (hold_send || pending_bytes.size() == 0) begin
        in_chan.valid <= 1'b0;
      end else if (send_gap > 0) begin
        send_gap--;
        in_chan.valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 14);
        in_chan.valid <= 1'b0;
      end else begin
        in_chan.valid          <= 1'b1;
        in_chan.data_byte      <= pending_bytes[0].data_byte;
        in_chan.byte_present   <= pending_bytes[0].byte_present;
        in_chan.end_of_message <= pending_bytes[0].end_of_message;
      end
    end
  end

  // Monitor: check each accepted digest word and drive ready with stall bursts.
  always @(posedge clk) begin
    digest_item_t got, want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.digest_word, out_chan.word_index, out_chan.last_word};
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest item %h", $time, got);
          mismatch_count++;
        end else begin
          want = digest_queue.pop_front();
          if (got.digest_word !== want.digest_word)
            $display("%0t: digest_word expected %h actual %h", $time,
                     want.digest_word, got.digest_word);
          if (got.word_index !== want.word_index)
            $display("%0t: word_index expected %0d actual %0d", $time,
                     want.word_index, got.word_index);
          if (got.last_word !== want.last_word)
            $display("%0t: last_word expected %b actual %b", $time,
                     want.last_word, got.last_word);
          if (got !== want) mismatch_count++;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_chan.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 14);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin
    int lens [3];
    in_chan.valid = 1'b0;
    in_chan.data_byte = '0;
    in_chan.byte_present = 1'b0;
    in_chan.end_of_message = 1'b0;
    out_chan.ready = 1'b0;
    reload_hash();
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, "abc", idle items, byte extremes.
    pending_bytes.push_back(mk(8'h00, 1'b0, 1'b1));
    pending_bytes.push_back(mk(8'h61, 1'b1, 1'b0));
    pending_bytes.push_back(mk(8'hff, 1'b0, 1'b0));
    pending_bytes.push_back(mk(8'h62, 1'b1, 1'b0));
    pending_bytes.push_back(mk(8'h63, 1'b1, 1'b1));
    pending_bytes.push_back(mk(8'h00, 1'b1, 1'b0));
    pending_bytes.push_back(mk(8'hff, 1'b1, 1'b0));
    pending_bytes.push_back(mk(8'h55, 1'b1, 1'b0));
    pending_bytes.push_back(mk(8'haa, 1'b0, 1'b1));
    queue_message(4, 1);

    // Pause until every digest has come back.
    wait (pending_bytes.size() == 0);
    hold_send = 1;
    while (digest_queue.size() != 0) @(posedge clk);
    @(posedge clk);
    hold_send = 0;

    // Random messages, including lengths across the 55/56 and 64 byte edges.
    lens = '{55, 56, 64};
    foreach (lens[i]) queue_message(lens[i], 1'($urandom_range(0, 1)));
    while (pending_bytes.size() < 190) begin
      queue_message($urandom_range(0, 20), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0)
        pending_bytes.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
    end
    wait (pending_bytes.size() < 60);
    quiet_tail = 1;
    queue_message(20, 1);
    queue_message(0, 0);
    wait (pending_bytes.size() == 0);
    wait (digest_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sm3_pkg.sv
hw/rtl/sm3_stream_if.sv
hw/rtl/sm3_front.sv
hw/rtl/sm3_word_fifo.sv
hw/rtl/sm3_compress.sv
hw/rtl/sm3_hash_engine_core.sv
test/sm3_hash_engine_core_test.sv
